[sv/rsfr_pkg.sv]
//------------------------------------------------------------------------------
// rsfr_pkg
// Shared types, constants and helpers of the serial frame receiver: receive
// phases, event codes, module error codes and the records that pass between
// the front end, the queues and the decoder.
//------------------------------------------------------------------------------
package rsfr_pkg;

   localparam int FRAME_STORE_BYTES_DEFAULT = 18;
   localparam int QUEUE_DEPTH_DEFAULT       = 2;

   localparam int CHECKED_BYTES = 12;

   localparam logic [7:0] SYNC_FIRST    = 8'hA5;
   localparam logic [7:0] SYNC_SECOND   = 8'h5A;
   localparam logic [7:0] LENGTH_MASK   = 8'h0F;
   localparam logic [7:0] HDR_MODULE    = 8'h8B;
   localparam logic [7:0] ORG_MODULE_OK = 8'h58;
   localparam logic [7:0] ORG_ID_BASE   = 8'h98;
   localparam logic [7:0] ORG_RPS       = 8'h05;
   localparam logic [7:0] BIT_PRESSED   = 8'h10;

   localparam logic [7:0] ORG_NOTWANTEDACK = 8'h28;
   localparam logic [7:0] ORG_NOTACK       = 8'h29;
   localparam logic [7:0] ORG_DUPID        = 8'h0C;
   localparam logic [7:0] ORG_HSEQ         = 8'h08;
   localparam logic [7:0] ORG_LENGTH       = 8'h09;
   localparam logic [7:0] ORG_CHECKSUM     = 8'h0A;
   localparam logic [7:0] ORG_ORG          = 8'h0B;
   localparam logic [7:0] ORG_TXIDRANGE    = 8'h22;
   localparam logic [7:0] ORG_IDRANGE      = 8'h1A;

   localparam logic [3:0] ERR_NOTWANTEDACK = 4'd0;
   localparam logic [3:0] ERR_NOTACK       = 4'd1;
   localparam logic [3:0] ERR_DUPID        = 4'd2;
   localparam logic [3:0] ERR_HSEQ         = 4'd3;
   localparam logic [3:0] ERR_LENGTH       = 4'd4;
   localparam logic [3:0] ERR_CHECKSUM     = 4'd5;
   localparam logic [3:0] ERR_ORG          = 4'd6;
   localparam logic [3:0] ERR_TXIDRANGE    = 4'd7;
   localparam logic [3:0] ERR_IDRANGE      = 4'd8;
   localparam logic [3:0] ERR_NONE         = 4'd0;

   localparam logic [4:0] LENGTH_OFFSET = 5'd3;
   localparam logic [4:0] FIRST_DATA_POS = 5'd3;
   localparam logic [3:0] UNIT_FIRST_BASE  = 4'd1;
   localparam logic [3:0] UNIT_SECOND_BASE = 4'd10;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_LENGTH,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef enum logic [2:0] {
      EV_CHECKSUM_ERROR = 3'd0,
      EV_MODULE_OK      = 3'd1,
      EV_MODULE_ERROR   = 3'd2,
      EV_ID_BASE        = 3'd3,
      EV_SWITCH         = 3'd4,
      EV_OTHER          = 3'd5
   } event_type;

   // The body holds store positions 2 to 13; body[k] is position k + 2.
   typedef struct packed {
      logic [7:0]                     rx_byte;
      logic [CHECKED_BYTES-1:0][7:0] body;
   } frame_type;

   typedef struct packed {
      event_type   kind;
      logic [3:0]  error_code;
      logic [31:0] sender_id;
      logic [3:0]  unit_code;
      logic        switch_on;
      logic [7:0]  frame_org;
      logic [7:0]  frame_status;
      logic [31:0] data_word;
      logic [31:0] current_id_base;
   } result_type;

   typedef struct packed {
      logic       known;
      logic       ok;
      logic [3:0] code;
   } module_org_type;

   function automatic module_org_type decode_module_org(input logic [7:0] org);
      module_org_type m;
      m = '{known: 1'b1, ok: 1'b0, code: ERR_NONE};
      unique case (org)
         ORG_MODULE_OK:    m.ok = 1'b1;
         ORG_NOTWANTEDACK: m.code = ERR_NOTWANTEDACK;
         ORG_NOTACK:       m.code = ERR_NOTACK;
         ORG_DUPID:        m.code = ERR_DUPID;
         ORG_HSEQ:         m.code = ERR_HSEQ;
         ORG_LENGTH:       m.code = ERR_LENGTH;
         ORG_CHECKSUM:     m.code = ERR_CHECKSUM;
         ORG_ORG:          m.code = ERR_ORG;
         ORG_TXIDRANGE:    m.code = ERR_TXIDRANGE;
         ORG_IDRANGE:      m.code = ERR_IDRANGE;
         default:          m.known = 1'b0;
      endcase
      return m;
   endfunction

endpackage

[sv/radio_serial_frame_receiver_core.sv]
//------------------------------------------------------------------------------
// A request that completes a frame has its event registered first in the frame
// queue and then in the result queue before it can be popped.
// Throughput: one request per cycle while neither queue is full, set by the
// receive state machine and the decoder, which each retire one entry a cycle.
// Reset is synchronous and active high; it clears the phase, the frame store,
// the positions, the ID base and both queues.
//------------------------------------------------------------------------------
// radio_serial_frame_receiver_core
// Serial frame receiver. A front end assembles frames from received bytes,
// a decoder checks and classifies them, and queues decouple the two.
//------------------------------------------------------------------------------
module radio_serial_frame_receiver_core
   import rsfr_pkg::*;
#(
   parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_error_code,
   output logic [31:0] rsp_sender_id,
   output logic [3:0]  rsp_unit_code,
   output logic        rsp_switch_on,
   output logic [7:0]  rsp_frame_org,
   output logic [7:0]  rsp_frame_status,
   output logic [31:0] rsp_data_word,
   output logic [31:0] rsp_current_id_base
);

   frame_type  front_data, back_data;
   result_type result_in, result_out;
   logic       mid_push, mid_full, mid_pop, mid_empty;
   logic       out_push, out_full;

   rsfr_front #(
      .FRAME_STORE_BYTES(FRAME_STORE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_data    (front_data)
   );

   rsfr_fifo #(
      .WIDTH($bits(frame_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_frame_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (back_data),
      .empty     (mid_empty)
   );

   rsfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (back_data),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (result_in)
   );

   rsfr_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (result_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (result_out),
      .empty     (rsp_empty)
   );

   assign rsp_event_kind      = result_out.kind;
   assign rsp_error_code      = result_out.error_code;
   assign rsp_sender_id       = result_out.sender_id;
   assign rsp_unit_code       = result_out.unit_code;
   assign rsp_switch_on       = result_out.switch_on;
   assign rsp_frame_org       = result_out.frame_org;
   assign rsp_frame_status    = result_out.frame_status;
   assign rsp_data_word       = result_out.data_word;
   assign rsp_current_id_base = result_out.current_id_base;

endmodule

[sv/rsfr_fifo.sv]
//------------------------------------------------------------------------------
// rsfr_fifo
// Small register queue with a push side and a pop side that stall on their
// own. The head entry is presented while empty is low.
//------------------------------------------------------------------------------
module rsfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Queue count exceeds its depth.");
`endif

endmodule

[sv/rsfr_front.sv]
//------------------------------------------------------------------------------
// rsfr_front
// Receive state machine. Hunts for the sync pair, reads the header, fills the
// frame store and hands a snapshot of the checked positions to the decoder
// queue when the checksum byte arrives.
//------------------------------------------------------------------------------
module rsfr_front
   import rsfr_pkg::*;
#(
   parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   input  logic       mid_full,
   output logic       mid_push,
   output frame_type  mid_data
);

   phase_type  phase_ff, phase_in;
   logic [7:0] store_ff [FRAME_STORE_BYTES];
   logic [7:0] store_in [FRAME_STORE_BYTES];
   logic [4:0] wp_ff, wp_in;
   logic [4:0] el_ff, el_in;
   logic [4:0] wp_step;
   logic       accept;
   logic       in_store;
   logic       data_done;

   assign req_full  = mid_full;
   assign accept    = req_push && !mid_full;
   assign wp_step   = (&wp_ff) ? wp_ff : wp_ff + 5'd1;
   assign in_store  = ({1'b0, wp_ff} < 6'(FRAME_STORE_BYTES));
   assign data_done = ({1'b0, wp_step} + 6'd1) >= {1'b0, el_ff};

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC1:  phase_in = (req_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:  phase_in = (req_rx_byte == SYNC_SECOND) ? PH_LENGTH : PH_SYNC1;
            PH_LENGTH: phase_in = PH_DATA;
            PH_DATA:   phase_in = data_done ? PH_CHECK : PH_DATA;
            PH_CHECK:  phase_in = PH_SYNC1;
            default:   phase_in = PH_SYNC1;
         endcase
      end
   end

   always_comb begin
      store_in = store_ff;
      wp_in    = wp_ff;
      el_in    = el_ff;
      mid_push = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_LENGTH: begin
               store_in[0] = SYNC_FIRST;
               store_in[1] = SYNC_SECOND;
               store_in[2] = req_rx_byte;
               el_in       = 5'(req_rx_byte & LENGTH_MASK) + LENGTH_OFFSET;
               wp_in       = FIRST_DATA_POS;
            end
            PH_DATA, PH_CHECK: begin
               for (int i = 0; i < FRAME_STORE_BYTES; i++) begin
                  if (in_store && (wp_ff == 5'(i))) begin
                     store_in[i] = req_rx_byte;
                  end
               end
               wp_in    = wp_step;
               mid_push = (phase_ff == PH_CHECK);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mid_data.rx_byte = req_rx_byte;
      for (int k = 0; k < CHECKED_BYTES; k++) begin
         mid_data.body[k] = (wp_ff == 5'(k + 2)) ? req_rx_byte : store_ff[k + 2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         wp_ff    <= '0;
         el_ff    <= '0;
         for (int i = 0; i < FRAME_STORE_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         el_ff    <= el_in;
         store_ff <= store_in;
      end
   end

`ifndef SYNTH
   a_frame_position: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_CHECK) |-> (wp_ff >= FIRST_DATA_POS))
      else $error("Write position is below the first data position in a frame.");
`endif

endmodule

[sv/rsfr_back.sv]
//------------------------------------------------------------------------------
// rsfr_back
// Frame decoder. Takes completed frames from the queue, checks the sum,
// classifies the frame, keeps the transceiver ID base and produces at most
// one event per frame.
//------------------------------------------------------------------------------
module rsfr_back
   import rsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       mid_empty,
   input  frame_type  mid_data,
   output logic       mid_pop,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_data
);

   logic [31:0]    id_base_ff, id_base_in;
   logic [7:0]     p0, p1, p2, p3, p4, q0, q1, q2, sum;
   logic [7:0]     hdr, org, db3, status, pos13, rx;
   module_org_type mo;
   logic           emit;
   logic           id_update;

   assign hdr    = mid_data.body[0];
   assign org    = mid_data.body[1];
   assign db3    = mid_data.body[2];
   assign status = mid_data.body[10];
   assign pos13  = mid_data.body[11];
   assign rx     = mid_data.rx_byte;

   assign p0  = mid_data.body[0] + mid_data.body[1];
   assign p1  = mid_data.body[2] + mid_data.body[3];
   assign p2  = mid_data.body[4] + mid_data.body[5];
   assign p3  = mid_data.body[6] + mid_data.body[7];
   assign p4  = mid_data.body[8] + mid_data.body[9];
   assign q0  = p0 + p1;
   assign q1  = p2 + p3;
   assign q2  = p4 + mid_data.body[10];
   assign sum = q0 + q1 + q2;

   assign mo      = decode_module_org(org);
   assign mid_pop = !mid_empty && !out_full;

   always_comb begin
      emit                     = 1'b1;
      id_update                = 1'b0;
      out_data.kind            = EV_OTHER;
      out_data.error_code      = ERR_NONE;
      out_data.unit_code       = '0;
      out_data.switch_on       = 1'b0;
      out_data.sender_id       = {mid_data.body[6], mid_data.body[7],
                                  mid_data.body[8], mid_data.body[9]};
      out_data.data_word       = {mid_data.body[2], mid_data.body[3],
                                  mid_data.body[4], mid_data.body[5]};
      out_data.frame_org       = org;
      out_data.frame_status    = status;
      out_data.current_id_base = id_base_ff;
      priority if (rx != sum) begin
         out_data.kind = EV_CHECKSUM_ERROR;
      end else if (pos13 != sum) begin
         emit = 1'b0;
      end else if ((hdr == HDR_MODULE) && mo.known && mo.ok) begin
         out_data.kind = EV_MODULE_OK;
      end else if ((hdr == HDR_MODULE) && mo.known) begin
         out_data.kind       = EV_MODULE_ERROR;
         out_data.error_code = mo.code;
      end else if (org == ORG_ID_BASE) begin
         out_data.kind            = EV_ID_BASE;
         out_data.current_id_base = {mid_data.body[2], mid_data.body[3],
                                     mid_data.body[4], mid_data.body[5]};
         id_update                = 1'b1;
      end else if (org == ORG_RPS) begin
         if (((status & BIT_PRESSED) == '0) || ((db3 & BIT_PRESSED) == '0)) begin
            emit = 1'b0;
         end else begin
            out_data.kind = EV_SWITCH;
            if (!db3[0]) begin
               out_data.unit_code = {2'b00, db3[7:6]} + UNIT_FIRST_BASE;
               out_data.switch_on = db3[5];
            end else begin
               out_data.unit_code = {2'b00, db3[3:2]} + UNIT_SECOND_BASE;
               out_data.switch_on = db3[1];
            end
         end
      end else begin
         out_data.kind = EV_OTHER;
      end
   end

   assign id_base_in = (mid_pop && id_update) ? out_data.data_word : id_base_ff;
   assign out_push   = mid_pop && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff <= '0;
      end else begin
         id_base_ff <= id_base_in;
      end
   end

`ifndef SYNTH
   a_id_base_hold: assert property (@(posedge clock) disable iff (reset)
      !(mid_pop && id_update) |=> $stable(id_base_ff))
      else $error("ID base changed without an ID base report.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_full |-> !mid_pop && !out_push)
      else $error("Decoder advanced while the result queue was full.");
`endif

endmodule

[tb/sv/radio_serial_frame_receiver_core_tb.sv]
//------------------------------------------------------------------------------
// radio_serial_frame_receiver_core_tb
// Feeds the frame receiver with serial bytes: a directed set of frames that
// covers every event kind, every module error, the switch decoding, checksum
// and stored checksum errors, short and long frames and sync recovery, then
// random frames mixed with noise and broken frames. A predictor of its own
// follows every accepted request and each event is compared with it.
//------------------------------------------------------------------------------
module radio_serial_frame_receiver_core_tb;
   import rsfr_pkg::*;

   localparam int FRAME_BYTES    = FRAME_STORE_BYTES_DEFAULT;
   localparam int SUM_FIRST      = 2;
   localparam int SUM_LAST       = 12;
   localparam int STORED_SUM_POS = 13;
   localparam int PLAN_ROWS      = 25;
   localparam int RANDOM_BYTES   = 500;
   localparam int SETTLE_CYCLES  = 10;
   localparam int STALL_LIMIT    = 4000;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [7:0]  header;
      logic [7:0]  org;
      logic [7:0]  status;
      logic [31:0] data;
      logic [31:0] sender;
      bit          sum_ok;
      bit          pos13_ok;
      bit          lead;
      bit          typed;
      bit          emits;
      event_type   kind;
      logic [3:0]  err;
      logic [3:0]  unit;
      logic        on;
   } frame_plan_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [2:0]  rsp_event_kind;
   logic [3:0]  rsp_error_code;
   logic [31:0] rsp_sender_id;
   logic [3:0]  rsp_unit_code;
   logic        rsp_switch_on;
   logic [7:0]  rsp_frame_org;
   logic [7:0]  rsp_frame_status;
   logic [31:0] rsp_data_word;
   logic [31:0] rsp_current_id_base;

   phase_type   rx_phase = PH_SYNC1;
   logic [7:0]  frame_mem [FRAME_BYTES] = '{default: 8'h00};
   logic [4:0]  wr_pos = '0;
   logic [4:0]  frame_len = '0;
   logic [31:0] id_base_q = '0;

   result_type  pending_events [$];
   result_type  seen;
   result_type  want;
   int          event_mismatches = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int          send_gap_pct = 30;
   int          pop_gap_pct = 30;

   logic [7:0]  lead_bytes [6] = '{8'h33, SYNC_FIRST, 8'h00, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND};
   logic [7:0]  org_picks [14] = '{ORG_MODULE_OK, ORG_NOTWANTEDACK, ORG_NOTACK, ORG_DUPID,
                                   ORG_HSEQ, ORG_LENGTH, ORG_CHECKSUM, ORG_ORG, ORG_TXIDRANGE,
                                   ORG_IDRANGE, ORG_ID_BASE, ORG_RPS, ORG_RPS, ORG_RPS};

   frame_plan_type dir_plan [PLAN_ROWS] = '{
      '{HDR_MODULE, ORG_MODULE_OK, 8'h00, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, EV_MODULE_OK, ERR_NONE, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_NOTWANTEDACK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_NOTWANTEDACK, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_NOTACK, 8'h12, 32'h0123_4567, 32'h89AB_CDEF,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_NOTACK, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_DUPID, 8'h80, 32'h8000_0001, 32'h0000_0080,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_DUPID, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_HSEQ, 8'h01, 32'h7F7F_7F7F, 32'h8080_8080,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_HSEQ, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_LENGTH, 8'h55, 32'hAAAA_5555, 32'h5555_AAAA,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_LENGTH, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_CHECKSUM, 8'hAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_CHECKSUM, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_ORG, 8'h3C, 32'h1357_9BDF, 32'h2468_ACE0,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_ORG, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_TXIDRANGE, 8'hC3, 32'hDEAD_0001, 32'h0000_BEEF,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_TXIDRANGE, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_IDRANGE, 8'h7E, 32'h1111_2222, 32'h3333_4444,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_MODULE_ERROR, ERR_IDRANGE, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_ID_BASE, 8'h00, 32'hFFFF_FFFF, 32'h1122_3344,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_ID_BASE, ERR_NONE, 4'd0, 1'b0},
      '{8'h0B, ORG_ID_BASE, 8'h5A, 32'h0000_0000, 32'hA5A5_A5A5,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_ID_BASE, ERR_NONE, 4'd0, 1'b0},
      '{HDR_MODULE, 8'h07, 8'h44, 32'h0102_0304, 32'h0506_0708,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h0B, ORG_MODULE_OK, 8'h99, 32'hFEDC_BA98, 32'h7654_3210,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h0B, ORG_RPS, 8'h30, 32'h3000_0000, 32'h0000_0001,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_SWITCH, ERR_NONE, 4'd1, 1'b1},
      '{HDR_MODULE, ORG_RPS, 8'h10, 32'hDF00_0000, 32'hFFFF_FFFE,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_SWITCH, ERR_NONE, 4'd13, 1'b1},
      '{8'h0B, ORG_RPS, 8'hD0, 32'h5CAB_CDEF, 32'h0102_0304,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EV_SWITCH, ERR_NONE, 4'd2, 1'b0},
      '{8'h0B, ORG_RPS, 8'h00, 32'hFF00_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h0B, ORG_RPS, 8'hFF, 32'hEF00_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{HDR_MODULE, ORG_MODULE_OK, 8'h21, 32'h1234_5678, 32'h9ABC_DEF0,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, EV_CHECKSUM_ERROR, ERR_NONE, 4'd0, 1'b0},
      '{8'h0F, ORG_MODULE_OK, 8'h00, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'hFF, ORG_ID_BASE, 8'h10, 32'hCAFE_0042, 32'h0BAD_F00D,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h00, ORG_MODULE_OK, 8'h00, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h07, ORG_RPS, 8'h10, 32'h1000_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0},
      '{8'h8C, ORG_MODULE_OK, 8'h00, 32'h0000_0000, 32'h0000_0000,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EV_OTHER, ERR_NONE, 4'd0, 1'b0}
   };

   radio_serial_frame_receiver_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_rx_byte         (req_rx_byte),
      .req_full            (req_full),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_error_code      (rsp_error_code),
      .rsp_sender_id       (rsp_sender_id),
      .rsp_unit_code       (rsp_unit_code),
      .rsp_switch_on       (rsp_switch_on),
      .rsp_frame_org       (rsp_frame_org),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_data_word       (rsp_data_word),
      .rsp_current_id_base (rsp_current_id_base)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] store_sum();
      logic [7:0] s;
      s = '0;
      for (int i = SUM_FIRST; i <= SUM_LAST; i++) s += frame_mem[i];
      return s;
   endfunction

   function automatic void store_rx_byte(input logic [7:0] c);
      if (wr_pos < FRAME_BYTES) frame_mem[wr_pos] = c;
      if (wr_pos < 5'd31) wr_pos++;
   endfunction

   function automatic bit parse_rx_byte(input logic [7:0] c, output result_type ev);
      logic [7:0] sum;
      logic [7:0] org;
      logic [7:0] status;
      logic [7:0] db3;
      logic [3:0] code;
      bit         module_org;
      ev = '0;
      case (rx_phase)
         PH_SYNC1: begin
            if (c == SYNC_FIRST) rx_phase = PH_SYNC2;
            return 1'b0;
         end
         PH_SYNC2: begin
            rx_phase = (c == SYNC_SECOND) ? PH_LENGTH : PH_SYNC1;
            return 1'b0;
         end
         PH_LENGTH: begin
            frame_mem[0] = SYNC_FIRST;
            frame_mem[1] = SYNC_SECOND;
            frame_mem[2] = c;
            frame_len = 5'(c & LENGTH_MASK) + LENGTH_OFFSET;
            wr_pos = FIRST_DATA_POS;
            rx_phase = PH_DATA;
            return 1'b0;
         end
         PH_DATA: begin
            store_rx_byte(c);
            if (int'(wr_pos) + 1 >= int'(frame_len)) rx_phase = PH_CHECK;
            return 1'b0;
         end
         default: ;
      endcase
      store_rx_byte(c);
      rx_phase = PH_SYNC1;
      sum = store_sum();
      org = frame_mem[3];
      status = frame_mem[12];
      db3 = frame_mem[4];
      ev.frame_org = org;
      ev.frame_status = status;
      ev.data_word = {frame_mem[4], frame_mem[5], frame_mem[6], frame_mem[7]};
      ev.sender_id = {frame_mem[8], frame_mem[9], frame_mem[10], frame_mem[11]};
      if (c != sum) begin
         ev.kind = EV_CHECKSUM_ERROR;
      end else if (frame_mem[STORED_SUM_POS] != sum) begin
         return 1'b0;
      end else begin
         module_org = 1'b1;
         code = ERR_NONE;
         case (org)
            ORG_MODULE_OK:    ;
            ORG_NOTWANTEDACK: code = ERR_NOTWANTEDACK;
            ORG_NOTACK:       code = ERR_NOTACK;
            ORG_DUPID:        code = ERR_DUPID;
            ORG_HSEQ:         code = ERR_HSEQ;
            ORG_LENGTH:       code = ERR_LENGTH;
            ORG_CHECKSUM:     code = ERR_CHECKSUM;
            ORG_ORG:          code = ERR_ORG;
            ORG_TXIDRANGE:    code = ERR_TXIDRANGE;
            ORG_IDRANGE:      code = ERR_IDRANGE;
            default:          module_org = 1'b0;
         endcase
         if (frame_mem[2] == HDR_MODULE && module_org) begin
            ev.kind = (org == ORG_MODULE_OK) ? EV_MODULE_OK : EV_MODULE_ERROR;
            ev.error_code = code;
         end else if (org == ORG_ID_BASE) begin
            id_base_q = ev.data_word;
            ev.kind = EV_ID_BASE;
         end else if (org == ORG_RPS) begin
            if ((status & BIT_PRESSED) == 8'h00 || (db3 & BIT_PRESSED) == 8'h00) return 1'b0;
            ev.kind = EV_SWITCH;
            if (!db3[0]) begin
               ev.unit_code = UNIT_FIRST_BASE + 4'(db3[7:6]);
               ev.switch_on = db3[5];
            end else begin
               ev.unit_code = UNIT_SECOND_BASE + 4'(db3[3:2]);
               ev.switch_on = db3[1];
            end
         end else begin
            ev.kind = EV_OTHER;
         end
      end
      ev.current_id_base = id_base_q;
      return 1'b1;
   endfunction

   function automatic string show_event(input result_type e);
      return {$sformatf("kind=%0d err=%0d id=%08h unit=%0d on=%0d ",
                        e.kind, e.error_code, e.sender_id, e.unit_code, e.switch_on),
              $sformatf("org=%02h st=%02h data=%08h base=%08h",
                        e.frame_org, e.frame_status, e.data_word, e.current_id_base)};
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(5))
         0:       return SYNC_FIRST;
         1:       return SYNC_SECOND;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic frame_plan_type random_plan();
      frame_plan_type p;
      int             sel;
      sel = $urandom_range(99);
      if (sel < 35) p.header = HDR_MODULE;
      else if (sel < 60) p.header = {4'($urandom_range(15)), 4'hB};
      else if (sel < 80) p.header = {4'($urandom_range(15)), 4'($urandom_range(15, 12))};
      else p.header = {4'($urandom_range(15)), 4'($urandom_range(10))};
      p.org = ($urandom_range(99) < 70) ? org_picks[$urandom_range(13)] : 8'($urandom_range(255));
      p.status = 8'($urandom_range(255));
      p.data = $urandom();
      p.sender = $urandom();
      if (p.org == ORG_RPS && $urandom_range(3) != 0) begin
         p.status = p.status | BIT_PRESSED;
         p.data[31:24] = p.data[31:24] | BIT_PRESSED;
      end
      p.sum_ok = ($urandom_range(9) != 0);
      p.pos13_ok = ($urandom_range(7) != 0);
      p.lead = ($urandom_range(9) == 0);
      p.typed = 1'b0;
      p.emits = 1'b0;
      p.kind = EV_OTHER;
      p.err = ERR_NONE;
      p.unit = '0;
      p.on = 1'b0;
      return p;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit keep_event);
      result_type ev;
      bit         hit;
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      hit = parse_rx_byte(b, ev);
      if (hit && keep_event) pending_events = {pending_events, ev};
   endtask

   task automatic send_frame(input frame_plan_type f);
      logic [7:0] body [FRAME_BYTES];
      logic [7:0] b;
      bit         at_check;
      result_type t;
      while (rx_phase != PH_SYNC1) send_byte(8'($urandom_range(255)), 1'b1);
      if (f.lead) foreach (lead_bytes[i]) send_byte(lead_bytes[i], 1'b1);
      foreach (body[i]) body[i] = 8'($urandom_range(255));
      body[3] = f.org;
      {body[4], body[5], body[6], body[7]} = f.data;
      {body[8], body[9], body[10], body[11]} = f.sender;
      body[12] = f.status;
      send_byte(SYNC_FIRST, 1'b1);
      send_byte(SYNC_SECOND, 1'b1);
      send_byte(f.header, 1'b1);
      while (rx_phase != PH_SYNC1) begin
         at_check = (rx_phase == PH_CHECK);
         if (at_check)
            b = f.sum_ok ? store_sum() : store_sum() + 8'($urandom_range(255, 1));
         else if (wr_pos == STORED_SUM_POS)
            b = f.pos13_ok ? store_sum() : store_sum() + 8'($urandom_range(255, 1));
         else
            b = body[wr_pos];
         send_byte(b, !(f.typed && at_check));
         if (f.typed && at_check && f.emits) begin
            t.kind = f.kind;
            t.error_code = f.err;
            t.sender_id = f.sender;
            t.unit_code = f.unit;
            t.switch_on = f.on;
            t.frame_org = f.org;
            t.frame_status = f.status;
            t.data_word = f.data;
            t.current_id_base = id_base_q;
            pending_events = {pending_events, t};
         end
      end
   endtask

   task automatic hold_until_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.kind = event_type'(rsp_event_kind);
            seen.error_code = rsp_error_code;
            seen.sender_id = rsp_sender_id;
            seen.unit_code = rsp_unit_code;
            seen.switch_on = rsp_switch_on;
            seen.frame_org = rsp_frame_org;
            seen.frame_status = rsp_frame_status;
            seen.data_word = rsp_data_word;
            seen.current_id_base = rsp_current_id_base;
            if (pending_events.size() == 0) begin
               if (event_mismatches < MAX_REPORTS)
                  $display("unexpected event: %s", show_event(seen));
               event_mismatches++;
            end else begin
               want = pending_events.pop_front();
               if (seen.kind !== want.kind || seen.error_code !== want.error_code ||
                   seen.sender_id !== want.sender_id || seen.unit_code !== want.unit_code ||
                   seen.switch_on !== want.switch_on || seen.frame_org !== want.frame_org ||
                   seen.frame_status !== want.frame_status ||
                   seen.data_word !== want.data_word ||
                   seen.current_id_base !== want.current_id_base) begin
                  if (event_mismatches < MAX_REPORTS)
                     $display("event mismatch: expected %s, got %s",
                              show_event(want), show_event(seen));
                  event_mismatches++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("radio_serial_frame_receiver_core_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int start;
      int pick;
      int done;
      bit drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_plan[i]) send_frame(dir_plan[i]);
      hold_until_drained();
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         done = bytes_sent - start;
         send_gap_pct = (done >= 100 && done < 250) ? 0 : 30;
         pop_gap_pct = send_gap_pct;
         if (!drained && done >= RANDOM_BYTES / 2) begin
            hold_until_drained();
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 82) begin
            send_frame(random_plan());
         end else if (pick < 92) begin
            repeat ($urandom_range(5, 1)) send_byte(noise_byte(), 1'b1);
         end else begin
            send_byte(SYNC_FIRST, 1'b1);
            send_byte(SYNC_SECOND, 1'b1);
            repeat ($urandom_range(8, 1)) send_byte(noise_byte(), 1'b1);
         end
      end
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (event_mismatches == 0 && pending_events.size() == 0)
         $display("radio_serial_frame_receiver_core_tb: clean");
      else
         $display("radio_serial_frame_receiver_core_tb: errors");
      $finish;
   end

endmodule
